// File: rtl/sfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_pkg: shared constants, types and helpers for the sortable FIFO queue
// Sizes, operation and status codes, storage write bundle, address helpers.
// ----------------------------------------------------------------------------
package sfq_pkg;

   localparam int DEPTH          = 16;
   localparam int VALUE_BITS     = 8;
   localparam int ADDR_BITS      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS     = $clog2(DEPTH + 1);

   localparam int FUNC_BITS      = 2;
   localparam int VALUE_IN_BITS  = 8;
   localparam int VALUE_OUT_BITS = 8;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 16;
   localparam int RSP_COUNT_LSB  = VALUE_OUT_BITS;

   localparam logic [FUNC_BITS-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SORT = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_POP  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [VALUE_BITS-1:0] data;
   } ram_wr_type;

   // base + offset, wrapped into the ring
   function automatic logic [ADDR_BITS-1:0] addr_wrap(input logic [ADDR_BITS-1:0] base,
                                                      input logic [ADDR_BITS-1:0] offset);
      logic [ADDR_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (ADDR_BITS + 1)'(DEPTH)) begin
         sum = sum - (ADDR_BITS + 1)'(DEPTH);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

   // clamp an incoming value to the storage width
   function automatic logic [VALUE_BITS-1:0] sat_value(input logic [VALUE_IN_BITS-1:0] v);
      logic [VALUE_BITS-1:0] res;
      if (40'(v) > 40'(VALUE_MAX)) begin
         res = VALUE_MAX;
      end else begin
         res = VALUE_BITS'(v);
      end
      return res;
   endfunction

endpackage

// File: rtl/sfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_ram: entry storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sfq_ram import sfq_pkg::*; (
   input  logic                  clock,
   input  ram_wr_type            wr,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sortable_fifo_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sortable_fifo_queue_core: bounded ring queue with in-place descending sort
// Push, sort and pop on entries held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Push, empty pop, full push and short sort give the result in the cycle after the
// item is taken; a pop first goes through the POP state for the RAM read.
// Sort of n >= 2 entries: bubble passes over len entries, len = n down to 2, each pass
// SFIRST, SRUN, SLAST, at most one RAM read and one write per cycle; the result follows the last pass.
// One item at a time; the next item is taken as the result leaves.
// Reset clears count, head pointer and result valid; RAM contents are kept.
// ----------------------------------------------------------------------------
module sortable_fifo_queue_core import sfq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [7:0] value_in
   input  logic [FUNC_BITS-1:0]     req_tuser,  // [1:0] func
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [7:0] value_out, [12:8] count_out, zero pad
   output logic [STATUS_BITS-1:0]   rsp_tuser   // [1:0] status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_POP    = 3'd1;
   localparam logic [2:0] ST_SFIRST = 3'd2;
   localparam logic [2:0] ST_SRUN   = 3'd3;
   localparam logic [2:0] ST_SLAST  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [ADDR_BITS-1:0]      head_ff, head_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [COUNT_BITS-1:0]     len_ff, len_in;
   logic [ADDR_BITS-1:0]      idx_ff, idx_in;
   logic [VALUE_BITS-1:0]     cur_ff, cur_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_OUT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   ram_wr_type                ram_wr;
   logic [ADDR_BITS-1:0]      ram_rd_addr;
   logic [VALUE_BITS-1:0]     ram_rd_data;

   logic                      accept;
   logic [FUNC_BITS-1:0]      func;

   sfq_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign func       = req_tuser;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr.en     = 1'b0;
      ram_wr.addr   = head_ff;
      ram_wr.data   = cur_ff;
      ram_rd_addr   = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = COUNT_OUT_BITS'(count_ff);
               case (func)
                  FUNC_PUSH: begin
                     if (count_ff == COUNT_BITS'(DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_wr.en    = 1'b1;
                        ram_wr.addr  = addr_wrap(head_ff, ADDR_BITS'(count_ff));
                        ram_wr.data  = sat_value(req_tdata[VALUE_IN_BITS-1:0]);
                        count_in     = count_ff + COUNT_BITS'(1);
                        rsp_count_in = COUNT_OUT_BITS'(count_ff + COUNT_BITS'(1));
                     end
                  end
                  FUNC_SORT: begin
                     if (count_ff >= COUNT_BITS'(2)) begin
                        // result comes at the end of the last pass
                        rsp_valid_in = 1'b0;
                        ram_rd_addr  = head_ff;
                        len_in       = count_ff;
                        state_in     = ST_SFIRST;
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_rd_addr  = head_ff;
                        head_in      = addr_wrap(head_ff, ADDR_BITS'(1));
                        count_in     = count_ff - COUNT_BITS'(1);
                        state_in     = ST_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = VALUE_OUT_BITS'(ram_rd_data);
            rsp_status_in = STATUS_OK;
            rsp_count_in  = COUNT_OUT_BITS'(count_ff);
            state_in      = ST_IDLE;
         end
         ST_SFIRST: begin
            // element 0 of the pass arrives; fetch element 1
            cur_in      = ram_rd_data;
            ram_rd_addr = addr_wrap(head_ff, ADDR_BITS'(1));
            idx_in      = ADDR_BITS'(1);
            state_in    = ST_SRUN;
         end
         ST_SRUN: begin
            // keep the smaller value moving toward the tail, write the larger back
            ram_wr.en   = 1'b1;
            ram_wr.addr = addr_wrap(head_ff, idx_ff - ADDR_BITS'(1));
            if (cur_ff < ram_rd_data) begin
               ram_wr.data = ram_rd_data;
               cur_in      = cur_ff;
            end else begin
               ram_wr.data = cur_ff;
               cur_in      = ram_rd_data;
            end
            if (COUNT_BITS'(idx_ff) == len_ff - COUNT_BITS'(1)) begin
               state_in = ST_SLAST;
            end else begin
               ram_rd_addr = addr_wrap(head_ff, idx_ff + ADDR_BITS'(1));
               idx_in      = idx_ff + ADDR_BITS'(1);
            end
         end
         ST_SLAST: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = addr_wrap(head_ff, ADDR_BITS'(len_ff - COUNT_BITS'(1)));
            ram_wr.data = cur_ff;
            len_in      = len_ff - COUNT_BITS'(1);
            if (len_ff == COUNT_BITS'(2)) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = COUNT_OUT_BITS'(count_ff);
               state_in      = ST_IDLE;
            end else begin
               ram_rd_addr = head_ff;
               state_in    = ST_SFIRST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - VALUE_OUT_BITS - COUNT_OUT_BITS)'(0),
                        rsp_count_ff, rsp_value_ff};

endmodule

// File: rtl/sfq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_checker: port-level checks for the sortable FIFO queue
// Result hold under stall, reset behavior, no item taken over a pending result, status and count agreement.
// ----------------------------------------------------------------------------
module sfq_checker import sfq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [STATUS_BITS-1:0]   rsp_tuser
);

   logic [COUNT_OUT_BITS-1:0] rsp_count;
   assign rsp_count = rsp_tdata[RSP_COUNT_LSB +: COUNT_OUT_BITS];

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // never take an item while an untaken result would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("item taken while result still pending");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != STATUS_EMPTY || rsp_count == '0) &&
                     (rsp_tuser != STATUS_FULL || rsp_count == COUNT_OUT_BITS'(DEPTH)))
      else $error("status disagrees with count");

endmodule

bind sortable_fifo_queue_core sfq_checker u_sfq_checker (.*);

// File: sim/sortable_fifo_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sortable_fifo_queue_core_tb: self-checking bench for the sortable FIFO queue
// Drives push, sort, pop and unused-selector items over the request stream,
// predicts each response from a local queue image and checks every response
// field, with random backpressure and gaps on both streams.
// ----------------------------------------------------------------------------
module sortable_fifo_queue_core_tb;
   import sfq_pkg::*;

   localparam logic [FUNC_BITS-1:0] FUNC_NOP = 2'd3;
   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 850;
   localparam int TAIL_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [VALUE_OUT_BITS-1:0] value_out;
      logic [STATUS_BITS-1:0]    status;
      logic [COUNT_OUT_BITS-1:0] count;
   } queue_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // [7:0] value_in
   logic [FUNC_BITS-1:0]     req_tuser = '0;  // [1:0] func
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // [7:0] value_out, [12:8] count_out, zero pad
   logic [STATUS_BITS-1:0]   rsp_tuser;       // [1:0] status

   // queue image kept in step with the accepted items
   logic [VALUE_BITS-1:0]    model_cells [DEPTH];
   logic [COUNT_OUT_BITS-1:0] model_count = '0;
   queue_rsp_type            pending_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int rsp_checked = 0;
   int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
   int n_sort = 0, n_full_sort = 0, n_nop = 0, peak_count = 0;

   sortable_fifo_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, pending_rsp.size());
         $display("[sortable_fifo_queue_core] ERROR");
         $finish;
      end
   end

   // apply one item to the queue image and return the response it must give
   function automatic queue_rsp_type predict_queue_op(input logic [FUNC_BITS-1:0] func,
                                                      input logic [VALUE_IN_BITS-1:0] value);
      queue_rsp_type         rsp;
      logic [VALUE_BITS-1:0] held;
      int                    i;
      int                    j;
      rsp = '0;
      case (func)
         FUNC_PUSH: begin
            n_push++;
            if (model_count >= DEPTH) begin
               rsp.status = STATUS_FULL;
               n_full++;
            end else begin
               model_cells[model_count[ADDR_BITS-1:0]] = (value > VALUE_MAX) ? VALUE_MAX : value;
               model_count = model_count + 1'b1;
            end
         end
         FUNC_SORT: begin
            n_sort++;
            if (model_count == DEPTH) n_full_sort++;
            // insertion sort, largest value toward the head
            for (i = 1; i < model_count; i++) begin
               held = model_cells[i];
               j = i - 1;
               while (j >= 0 && model_cells[j] < held) begin
                  model_cells[j + 1] = model_cells[j];
                  j--;
               end
               model_cells[j + 1] = held;
            end
         end
         FUNC_POP: begin
            n_pop++;
            if (model_count == 0) begin
               rsp.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               rsp.value_out = model_cells[0];
               for (i = 0; i + 1 < model_count; i++) model_cells[i] = model_cells[i + 1];
               model_count = model_count - 1'b1;
            end
         end
         default: begin
            n_nop++;
         end
      endcase
      rsp.status = (rsp.status === 'x) ? STATUS_OK : rsp.status;
      rsp.count  = model_count;
      if (model_count > peak_count) peak_count = model_count;
      return rsp;
   endfunction

   // leaves req_tvalid high so a following item goes out without a bubble
   task automatic send_item(input logic [FUNC_BITS-1:0] func,
                            input logic [VALUE_IN_BITS-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_queue_op(func, value));
   endtask

   // hold off the sender until every response has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      queue_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected response: tdata %h tuser %h", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_tdata[VALUE_OUT_BITS-1:0] !== want.value_out ||
                rsp_tuser !== want.status ||
                rsp_tdata[RSP_COUNT_LSB +: COUNT_OUT_BITS] !== want.count ||
                rsp_tdata[RSP_DATA_BITS-1:RSP_COUNT_LSB+COUNT_OUT_BITS] !== '0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("response %0d mismatch: value %h/%h status %h/%h count %0d/%0d pad %h",
                           rsp_checked, want.value_out, rsp_tdata[VALUE_OUT_BITS-1:0],
                           want.status, rsp_tuser, want.count,
                           rsp_tdata[RSP_COUNT_LSB +: COUNT_OUT_BITS],
                           rsp_tdata[RSP_DATA_BITS-1:RSP_COUNT_LSB+COUNT_OUT_BITS]);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // pop and sort on an empty queue, then a single entry
   task automatic test_empty_queue();
      send_item(FUNC_POP, 8'h00);
      send_item(FUNC_SORT, 8'h00);
      send_item(FUNC_PUSH, 8'hFF);
      send_item(FUNC_SORT, 8'h00);
      send_item(FUNC_POP, 8'h00);
   endtask

   // fill every cell, duplicates included, then push once more into a full queue
   task automatic test_fill_to_full();
      logic [VALUE_IN_BITS-1:0] fill [DEPTH] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                                 8'h7F, 8'hFE, 8'h55, 8'h00, 8'hFF, 8'h10,
                                                 8'h0F, 8'hF0, 8'h33, 8'hCC};
      int i;
      for (i = 0; i < DEPTH; i++) send_item(FUNC_PUSH, fill[i]);
      send_item(FUNC_PUSH, 8'h3C);
   endtask

   // sort the full queue, try the unused selector, pop the largest
   task automatic test_sort_full();
      send_item(FUNC_SORT, 8'h00);
      send_item(FUNC_NOP, 8'hFF);
      send_item(FUNC_POP, 8'h00);
      wait_drain();
   endtask

   // bursts that lean toward filling or draining, so the count sweeps its range
   task automatic test_random_mix(input int n_items, input int s_idle, input int r_idle);
      int sent;
      int burst;
      int roll;
      int push_pct;
      logic [FUNC_BITS-1:0] func;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(10, 40);
         push_pct = $urandom_range(0, 1) ? 55 : 25;
         while (burst > 0 && sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) func = FUNC_PUSH;
            else if (roll < push_pct + 15) func = FUNC_SORT;
            else if (roll < 95) func = FUNC_POP;
            else func = FUNC_NOP;
            send_item(func, 8'($urandom));
            burst--;
            sent++;
         end
         if ($urandom_range(0, 5) == 0) wait_drain();
      end
      wait_drain();
   endtask

   initial begin
      send_idle_pct = 26;
      recv_idle_pct = 57;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_to_full();
      test_sort_full();
      test_random_mix(RANDOM_ITEMS / 3, 26, 57);
      test_random_mix(RANDOM_ITEMS / 3, 57, 26);
      test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += pending_rsp.size();
      $display("checked %0d responses: %0d pushes (%0d dropped full), %0d pops (%0d empty)",
               rsp_checked, n_push, n_full, n_pop, n_empty);
      $display("%0d sorts (%0d on a full queue), %0d unused selectors, peak depth %0d",
               n_sort, n_full_sort, n_nop, peak_count);
      if (error_count == 0) begin
         $display("[sortable_fifo_queue_core] OK");
      end else begin
         $display("%0d failures", error_count);
         $display("[sortable_fifo_queue_core] ERROR");
      end
      $finish;
   end

endmodule
